@@ rtl/avo_pkg.sv @@
// Shared types, constants and float helper functions for the vertex transform block.
`timescale 1ns / 1ps

package avo_pkg;

    // Coefficient store layout
    localparam int COEF_SLOTS    = 18;
    localparam int COEF_IDX_W    = 5;
    localparam int SLOT_X_TERM   = 0;
    localparam int SLOT_Y_TERM   = 3;
    localparam int SLOT_Z_TERM   = 6;
    localparam int SLOT_T_TERM   = 9;
    localparam int BOX_MIN_BASE  = 12;
    localparam int BOX_MAX_BASE  = 15;
    localparam int NUM_AXES      = 3;

    // Item kinds carried in tuser
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_VERTEX  = 1'b1;

    localparam logic [31:0] CANON_NAN = 32'h7FC00000;

    // Internal unpacked double format
    localparam int EXP_W = 12;
    localparam int MAN_W = 53;

    // Pipeline depths
    localparam int PROD_LAT   = 3;
    localparam int DADD_LAT   = 6;
    localparam int DTOF_LAT   = 2;
    localparam int AXIS_LAT   = PROD_LAT + 3 * DADD_LAT + DTOF_LAT;
    localparam int PIPE_DEPTH = AXIS_LAT + 2;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 104;

    typedef struct packed {
        logic                    nan;
        logic                    inf;
        logic                    zero;
        logic                    sign;
        logic signed [EXP_W-1:0] exp;   // exponent of the leading bit
        logic [MAN_W-1:0]        man;   // bit 52 set for finite nonzero values
    } fp_t;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc56(input logic [55:0] v);
        logic [5:0] n;
        n = 6'd56;
        for (int i = 0; i < 56; i++) begin
            if (v[i]) n = 6'(55 - i);
        end
        return n;
    endfunction

    // Unpack single-precision bits, normalizing subnormals
    function automatic fp_t unpack_sp(input logic [31:0] bits);
        logic [7:0]  e;
        logic [22:0] f;
        logic [4:0]  lz;
        logic [23:0] m;
        fp_t         r;
        e      = bits[30:23];
        f      = bits[22:0];
        lz     = lzc24({1'b0, f});
        m      = {1'b0, f} << lz;
        r.sign = bits[31];
        r.nan  = (e == 8'hFF) && (f != 23'd0);
        r.inf  = (e == 8'hFF) && (f == 23'd0);
        r.zero = (e == 8'd0) && (f == 23'd0);
        if (e == 8'd0) begin
            r.exp = -12'sd126 - $signed({7'd0, lz});
            r.man = {m, 29'd0};
        end
        else begin
            r.exp = $signed({4'd0, e}) - 12'sd127;
            r.man = {1'b1, f, 29'd0};
        end
        return r;
    endfunction

    // Ordered less-than on single-precision bits; false when either is NaN
    function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
        logic an;
        logic bn;
        an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        if (an || bn) return 1'b0;
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b0;
        if (a[31] != b[31]) return a[31];
        if (!a[31]) return a[30:0] < b[30:0];
        return a[30:0] > b[30:0];
    endfunction

endpackage

@@ rtl/avo_prod.sv @@
// Three-stage exact single-by-single product into the internal double format.
`timescale 1ns / 1ps

module avo_prod
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  logic [31:0]     coef,
    input  logic [31:0]     coord,
    output logic            out_valid,
    output avo_pkg::fp_t    out
);

    avo_pkg::fp_t a_reg;
    avo_pkg::fp_t b_reg;
    logic         v1_reg;
    logic [47:0]  p_reg;
    logic signed [avo_pkg::EXP_W-1:0] e2_reg;
    logic         nan2_reg;
    logic         inf2_reg;
    logic         zero2_reg;
    logic         sign2_reg;
    logic         v2_reg;
    avo_pkg::fp_t out_reg;
    avo_pkg::fp_t out_next;
    logic         v3_reg;

    // Unpack stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg <= avo_pkg::unpack_sp(coef);
            b_reg <= avo_pkg::unpack_sp(coord);
        end
    end

    // Multiply stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_reg     <= a_reg.man[52:29] * b_reg.man[52:29];
            e2_reg    <= a_reg.exp + b_reg.exp;
            nan2_reg  <= a_reg.nan | b_reg.nan | (a_reg.inf & b_reg.zero)
                         | (a_reg.zero & b_reg.inf);
            inf2_reg  <= a_reg.inf | b_reg.inf;
            zero2_reg <= a_reg.zero | b_reg.zero;
            sign2_reg <= a_reg.sign ^ b_reg.sign;
        end
    end

    // Normalize stage: the product leads at bit 47 or 46
    always_comb
    begin
        out_next      = '0;
        out_next.sign = sign2_reg;
        out_next.nan  = nan2_reg;
        out_next.inf  = !nan2_reg && inf2_reg;
        out_next.zero = !nan2_reg && !inf2_reg && zero2_reg;
        if (p_reg[47])
        begin
            out_next.exp = e2_reg + 12'sd1;
            out_next.man = {p_reg, 5'd0};
        end
        else
        begin
            out_next.exp = e2_reg;
            out_next.man = {p_reg[46:0], 6'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out       = out_reg;
    assign out_valid = v3_reg;

endmodule

@@ rtl/avo_dadd.sv @@
// Six-stage double-precision adder, round to nearest even, on the internal format.
`timescale 1ns / 1ps

module avo_dadd
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  avo_pkg::fp_t    a,
    input  avo_pkg::fp_t    b,
    output logic            out_valid,
    output avo_pkg::fp_t    out
);

    localparam int LAT = avo_pkg::DADD_LAT;

    logic [LAT-1:0] v_reg;

    // stage 1: order operands, special cases
    avo_pkg::fp_t big1_reg, sml1_reg, spec1_reg;
    logic [5:0]   d1_reg;
    logic         sub1_reg, usp1_reg;
    // stage 2: alignment
    logic [55:0]  bx2_reg, al2_reg;
    logic signed [avo_pkg::EXP_W-1:0] e2_reg, e3_reg, e4_reg, e5_reg, e6_next;
    logic         sub2_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    avo_pkg::fp_t spec2_reg, spec3_reg, spec4_reg, spec5_reg;
    logic         usp2_reg, usp3_reg, usp4_reg, usp5_reg;
    // stage 3: sum
    logic [56:0]  sum3_reg;
    // stage 4: leading zeros
    logic [56:0]  sum4_reg;
    logic [5:0]   lz4_reg;
    logic         z4_reg, z5_reg;
    // stage 5: normalized, round decision
    logic [52:0]  m5_reg;
    logic         inc5_reg;

    avo_pkg::fp_t big, sml, spec, out_reg, out_next;
    logic         a_big, usp;
    logic signed [avo_pkg::EXP_W-1:0] dfull;
    logic [5:0]   d;
    logic [55:0]  sx, sh, al;
    logic         sticky;
    logic [55:0]  n;
    logic signed [avo_pkg::EXP_W-1:0] e5_next;
    logic [53:0]  rnd;

    always_comb
    begin
        a_big = (a.exp > b.exp) || ((a.exp == b.exp) && (a.man >= b.man));
        big   = a_big ? a : b;
        sml   = a_big ? b : a;
        dfull = big.exp - sml.exp;
        d     = (dfull > 12'sd63) ? 6'd63 : dfull[5:0];
        usp   = a.nan | a.inf | a.zero | b.nan | b.inf | b.zero;
        spec  = '0;
        if (a.nan | b.nan | (a.inf & b.inf & (a.sign != b.sign)))
            spec.nan = 1'b1;
        else if (a.inf | b.inf)
        begin
            spec.inf  = 1'b1;
            spec.sign = a.inf ? a.sign : b.sign;
        end
        else if (a.zero & b.zero)
        begin
            spec.zero = 1'b1;
            spec.sign = a.sign & b.sign;
        end
        else if (a.zero)
            spec = b;
        else
            spec = a;
    end

    always_comb
    begin
        sx     = {sml1_reg.man, 3'd0};
        sh     = sx >> d1_reg;
        sticky = (sx & ~({56{1'b1}} << d1_reg)) != 56'd0;
        al     = {sh[55:1], sh[0] | sticky};
    end

    // Normalize: carry shifts right one, cancellation shifts left
    always_comb
    begin
        if (sum4_reg[56])
        begin
            n       = {sum4_reg[56:2], sum4_reg[1] | sum4_reg[0]};
            e5_next = e4_reg + 12'sd1;
        end
        else
        begin
            n       = sum4_reg[55:0] << lz4_reg;
            e5_next = e4_reg - $signed({6'd0, lz4_reg});
        end
    end

    always_comb
    begin
        rnd     = {1'b0, m5_reg} + {53'd0, inc5_reg};
        e6_next = rnd[53] ? e5_reg + 12'sd1 : e5_reg;
        out_next      = '0;
        out_next.sign = s5_reg;
        out_next.exp  = e6_next;
        out_next.man  = rnd[53] ? rnd[53:1] : rnd[52:0];
        if (usp5_reg)
            out_next = spec5_reg;
        else if (z5_reg)
        begin
            out_next      = '0;
            out_next.zero = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            big1_reg  <= big;
            sml1_reg  <= sml;
            d1_reg    <= d;
            sub1_reg  <= a.sign ^ b.sign;
            spec1_reg <= spec;
            usp1_reg  <= usp;

            bx2_reg   <= {big1_reg.man, 3'd0};
            al2_reg   <= al;
            e2_reg    <= big1_reg.exp;
            s2_reg    <= big1_reg.sign;
            sub2_reg  <= sub1_reg;
            spec2_reg <= spec1_reg;
            usp2_reg  <= usp1_reg;

            sum3_reg  <= sub2_reg ? {1'b0, bx2_reg} - {1'b0, al2_reg}
                                  : {1'b0, bx2_reg} + {1'b0, al2_reg};
            e3_reg    <= e2_reg;
            s3_reg    <= s2_reg;
            spec3_reg <= spec2_reg;
            usp3_reg  <= usp2_reg;

            sum4_reg  <= sum3_reg;
            lz4_reg   <= avo_pkg::lzc56(sum3_reg[55:0]);
            z4_reg    <= sum3_reg == 57'd0;
            e4_reg    <= e3_reg;
            s4_reg    <= s3_reg;
            spec4_reg <= spec3_reg;
            usp4_reg  <= usp3_reg;

            m5_reg    <= n[55:3];
            inc5_reg  <= n[2] & (n[1] | n[0] | n[3]);
            e5_reg    <= e5_next;
            z5_reg    <= z4_reg;
            s5_reg    <= s4_reg;
            spec5_reg <= spec4_reg;
            usp5_reg  <= usp4_reg;

            out_reg   <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (advance)
            v_reg <= {v_reg[LAT-2:0], in_valid};
    end

    assign out       = out_reg;
    assign out_valid = v_reg[LAT-1];

endmodule

@@ rtl/avo_dtof.sv @@
// Two-stage rounding from the internal double format to single-precision bits.
`timescale 1ns / 1ps

module avo_dtof
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  avo_pkg::fp_t    a,
    output logic            out_valid,
    output logic [31:0]     out_bits
);

    logic         normal;
    logic signed [avo_pkg::EXP_W-1:0] shw;
    logic [5:0]   sh;
    logic [53:0]  q1;
    logic [23:0]  qv;
    logic         sticky;
    logic [7:0]   ebias;
    logic [31:0]  base;

    logic [31:0]  base_reg;
    logic         inc_reg, over_reg, nan_reg, inf_reg, zero_reg, sign_reg, v1_reg;
    logic [31:0]  bits_reg, bits_next;
    logic         v2_reg;

    always_comb
    begin
        normal = a.exp >= -12'sd126;
        shw    = -12'sd97 - a.exp;
        if (normal)
            sh = 6'd29;
        else
            sh = (shw > 12'sd63) ? 6'd63 : shw[5:0];
        q1     = {a.man, 1'b0} >> sh;
        qv     = q1[24:1];
        sticky = (a.man & ~({53{1'b1}} << (sh - 6'd1))) != 53'd0;
        ebias  = 8'(a.exp + 12'sd127);
        base   = normal ? {a.sign, ebias, qv[22:0]} : {a.sign, 8'd0, qv[22:0]};
    end

    always_comb
    begin
        if (nan_reg)
            bits_next = avo_pkg::CANON_NAN;
        else if (inf_reg || over_reg)
            bits_next = {sign_reg, 8'hFF, 23'd0};
        else if (zero_reg)
            bits_next = {sign_reg, 31'd0};
        else
            bits_next = base_reg + {31'd0, inc_reg};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            base_reg <= base;
            inc_reg  <= q1[0] & (sticky | qv[0]);
            over_reg <= a.exp > 12'sd127;
            nan_reg  <= a.nan;
            inf_reg  <= a.inf;
            zero_reg <= a.zero;
            sign_reg <= a.sign;
            bits_reg <= bits_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_bits  = bits_reg;
    assign out_valid = v2_reg;

endmodule

@@ rtl/avo_axis.sv @@
// One output axis: three products, three chained double adds, rounding to single.
`timescale 1ns / 1ps

module avo_axis
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  logic [31:0]     coord_x,
    input  logic [31:0]     coord_y,
    input  logic [31:0]     coord_z,
    input  logic [31:0]     coef_x,
    input  logic [31:0]     coef_y,
    input  logic [31:0]     coef_z,
    input  logic [31:0]     coef_t,
    output logic            out_valid,
    output logic [31:0]     out_bits
);

    localparam int DL = avo_pkg::DADD_LAT;

    avo_pkg::fp_t zt, yt, xt, s1, s2, s3;
    avo_pkg::fp_t xt_dly_reg [DL];
    avo_pkg::fp_t t_reg;
    logic         p_valid, s1_valid, s2_valid, s3_valid;

    avo_prod u_prod_z
    (
        .clk(clk), .rst_n(rst_n), .advance(advance), .in_valid(in_valid),
        .coef(coef_z), .coord(coord_z), .out_valid(p_valid), .out(zt)
    );

    avo_prod u_prod_y
    (
        .clk(clk), .rst_n(rst_n), .advance(advance), .in_valid(in_valid),
        .coef(coef_y), .coord(coord_y), .out_valid(), .out(yt)
    );

    avo_prod u_prod_x
    (
        .clk(clk), .rst_n(rst_n), .advance(advance), .in_valid(in_valid),
        .coef(coef_x), .coord(coord_x), .out_valid(), .out(xt)
    );

    // Hold the x term until the first sum is ready
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xt_dly_reg[0] <= xt;
            for (int i = 1; i < DL; i++) xt_dly_reg[i] <= xt_dly_reg[i-1];
        end
    end

    // Translation follows the store; the store holds still while vertices are in flight
    always_ff @(posedge clk)
    begin
        t_reg <= avo_pkg::unpack_sp(coef_t);
    end

    avo_dadd u_add_zy
    (
        .clk(clk), .rst_n(rst_n), .advance(advance), .in_valid(p_valid),
        .a(zt), .b(yt), .out_valid(s1_valid), .out(s1)
    );

    avo_dadd u_add_x
    (
        .clk(clk), .rst_n(rst_n), .advance(advance), .in_valid(s1_valid),
        .a(s1), .b(xt_dly_reg[DL-1]), .out_valid(s2_valid), .out(s2)
    );

    avo_dadd u_add_t
    (
        .clk(clk), .rst_n(rst_n), .advance(advance), .in_valid(s2_valid),
        .a(s2), .b(t_reg), .out_valid(s3_valid), .out(s3)
    );

    avo_dtof u_dtof
    (
        .clk(clk), .rst_n(rst_n), .advance(advance), .in_valid(s3_valid),
        .a(s3), .out_valid(out_valid), .out_bits(out_bits)
    );

endmodule

@@ rtl/affine_vertex_outcode.sv @@
// Top level: affine vertex transform with box outcode, streaming in and out.
//
//  channel | dir | tdata                                         | tuser   | tlast
//  --------+-----+-----------------------------------------------+---------+-----------
//  s_axis  | in  | coef_index, coef_value, vertex_x, _y, _z      | command | batch_last
//  m_axis  | out | out_x, out_y, out_z, outcode                  | -       | batch_end
//
//  One vertex per cycle while m_axis is not stalled; from acceptance to m_axis_tvalid
//  each vertex passes the input register, 3 product stages, three 6-stage double adders
//  in series, 2 rounding stages and the outcode/output register.
//  A load transaction waits until no vertex is in flight, then writes the store;
//  vertices after it see the new word.
//  rst_n clears all valid bits, the in-flight count and the coefficient store.
//  A stall on m_axis freezes every stage at once; nothing is dropped or repeated.
`timescale 1ns / 1ps

module affine_vertex_outcode
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [4:0] coef_index, [36:5] coef_value, [68:37] vertex_x, [100:69] vertex_y,
    // [132:101] vertex_z, rest zero
    input  logic [avo_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] command
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z, [101:96] outcode, rest zero
    output logic [avo_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast
);

    localparam int NA = avo_pkg::NUM_AXES;

    logic [31:0]  coef_reg [avo_pkg::COEF_SLOTS];

    logic         advance;
    logic         vtx_acc;
    logic         load_acc;
    logic         out_acc;
    logic [avo_pkg::COEF_IDX_W-1:0] load_idx;

    logic [avo_pkg::CNT_W-1:0] inflight_reg;

    // input register
    logic         s0_valid_reg;
    logic [31:0]  s0_x_reg, s0_y_reg, s0_z_reg;
    logic         s0_last_reg;

    logic         last_dly_reg [avo_pkg::AXIS_LAT];

    logic [NA-1:0] ax_valid;
    logic [31:0]   ax_bits [NA];

    logic [5:0]   outcode;
    logic         out_valid_reg;
    logic [31:0]  out_x_reg, out_y_reg, out_z_reg;
    logic [5:0]   outcode_reg;
    logic         out_last_reg;

    // Hold the whole pipeline while the output register is full and not taken
    assign advance  = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance &&
                           ((s_axis_tuser == avo_pkg::CMD_VERTEX) || (inflight_reg == '0));
    assign vtx_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == avo_pkg::CMD_VERTEX);
    assign load_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == avo_pkg::CMD_LOAD);
    assign out_acc  = out_valid_reg && m_axis_tready;
    assign load_idx = s_axis_tdata[4:0];

    // Coefficient store; drop loads to slots past the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < avo_pkg::COEF_SLOTS; i++) coef_reg[i] <= 32'd0;
        end
        else if (load_acc && (load_idx < avo_pkg::COEF_IDX_W'(avo_pkg::COEF_SLOTS)))
        begin
            coef_reg[load_idx] <= s_axis_tdata[36:5];
        end
    end

    // Count vertices between acceptance and delivery
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else if (vtx_acc && !out_acc)
            inflight_reg <= inflight_reg + 1'b1;
        else if (!vtx_acc && out_acc)
            inflight_reg <= inflight_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (advance)
            s0_valid_reg <= vtx_acc;
    end

    always_ff @(posedge clk)
    begin
        if (advance && vtx_acc)
        begin
            s0_x_reg    <= s_axis_tdata[68:37];
            s0_y_reg    <= s_axis_tdata[100:69];
            s0_z_reg    <= s_axis_tdata[132:101];
            s0_last_reg <= s_axis_tlast;
        end
    end

    // batch_last rides alongside the axis pipelines
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            last_dly_reg[0] <= s0_last_reg;
            for (int i = 1; i < avo_pkg::AXIS_LAT; i++) last_dly_reg[i] <= last_dly_reg[i-1];
        end
    end

    for (genvar g = 0; g < NA; g++)
    begin : g_axis
        avo_axis u_axis
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .in_valid (s0_valid_reg),
            .coord_x  (s0_x_reg),
            .coord_y  (s0_y_reg),
            .coord_z  (s0_z_reg),
            .coef_x   (coef_reg[avo_pkg::SLOT_X_TERM + g]),
            .coef_y   (coef_reg[avo_pkg::SLOT_Y_TERM + g]),
            .coef_z   (coef_reg[avo_pkg::SLOT_Z_TERM + g]),
            .coef_t   (coef_reg[avo_pkg::SLOT_T_TERM + g]),
            .out_valid(ax_valid[g]),
            .out_bits (ax_bits[g])
        );

        // Below-min wins over above-max; NaN on either side sets neither
        logic below;
        assign below = avo_pkg::flt_lt(ax_bits[g], coef_reg[avo_pkg::BOX_MIN_BASE + g]);
        assign outcode[2*g]   = below;
        assign outcode[2*g+1] = !below &&
                                avo_pkg::flt_lt(coef_reg[avo_pkg::BOX_MAX_BASE + g], ax_bits[g]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= ax_valid[0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_x_reg    <= ax_bits[0];
            out_y_reg    <= ax_bits[1];
            out_z_reg    <= ax_bits[2];
            outcode_reg  <= outcode;
            out_last_reg <= last_dly_reg[avo_pkg::AXIS_LAT-1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'd0, outcode_reg, out_z_reg, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ rtl/avo_checker.sv @@
// Port-level checks for the vertex transform block, bound to the top level.
`timescale 1ns / 1ps

module avo_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [avo_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A load never overtakes a vertex still waiting at the output
    a_load_waits: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && (s_axis_tuser == avo_pkg::CMD_LOAD) && m_axis_tvalid
        |-> !s_axis_tready)
        else $error("load accepted with a vertex in flight");

    // Below and above are exclusive on every axis
    a_code_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[96] && m_axis_tdata[97]) &&
                          !(m_axis_tdata[98] && m_axis_tdata[99]) &&
                          !(m_axis_tdata[100] && m_axis_tdata[101]))
        else $error("outcode has both bits of an axis set");

    // A NaN x result never sets its outcode pair
    a_nan_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[31:0] == avo_pkg::CANON_NAN)
        |-> m_axis_tdata[97:96] == 2'b00)
        else $error("NaN x result with outcode bits set");

endmodule

bind affine_vertex_outcode avo_checker u_avo_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
